FILE: design/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms for the cache design files.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define LKVC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LKVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, operation codes, entry and cell control types.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CFG_W = 5;

	localparam logic [CFG_W-1:0] CFG_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] PUT_VALUE  = {VAL_W{1'b0}};

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic upd;
		logic head;
	} cell_ctl_t;

endpackage

FILE: design/lkvc_cell.sv
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One recency slot: holds an entry, compares it against the lookup key and
// takes the entry of its more recent neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module lkvc_cell #(
	parameter int INDEX = 0,
	parameter int CNTW  = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lkvc_pkg::cell_ctl_t       ctl,
	input  logic [CNTW-1:0]           limit,
	input  logic [lkvc_pkg::KEY_W-1:0] key_cmp,
	input  lkvc_pkg::entry_t          prev,
	output lkvc_pkg::entry_t          ent,
	output logic                      match
);

	logic                       valid_q;
	logic                       match_q;
	logic [lkvc_pkg::KEY_W-1:0] key_q;
	logic [lkvc_pkg::VAL_W-1:0] value_q;
	logic                       take;

	assign take = ctl.upd && ctl.head && (CNTW'(INDEX) <= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= prev.valid;
			end
			if (ctl.cmp) begin
				match_q <= valid_q && (key_q == key_cmp);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.value = value_q;
	assign match     = match_q;

endmodule

FILE: design/lkvc_chain.sv
// ----------------------------------------------------------------------------
// LRU key-value cache cell chain
// Row of cells ordered most recent first; cell 0 takes the head entry and
// each other cell takes its neighbor's. Reduces the match flags to the hit
// position and the hit value.
// ----------------------------------------------------------------------------
module lkvc_chain #(
	parameter int CAPACITY = 16,
	parameter int CNTW     = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkvc_pkg::cell_ctl_t        ctl,
	input  logic [CNTW-1:0]            limit,
	input  logic [lkvc_pkg::KEY_W-1:0] key_cmp,
	input  lkvc_pkg::entry_t           head,
	output logic                       lookup_hit,
	output logic [CNTW-1:0]            hit_pos,
	output logic [lkvc_pkg::VAL_W-1:0] hit_value,
	output logic [CAPACITY-1:0]        valid_vec,
	output logic [CAPACITY-1:0]        match_vec
);

	lkvc_pkg::entry_t ents [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lkvc_pkg::entry_t prev;
		if (i == 0) begin : g_head
			assign prev = head;
		end else begin : g_link
			assign prev = ents[i-1];
		end
		lkvc_cell #(
			.INDEX (i),
			.CNTW  (CNTW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.limit   (limit),
			.key_cmp (key_cmp),
			.prev    (prev),
			.ent     (ents[i]),
			.match   (match_vec[i])
		);
		assign valid_vec[i] = ents[i].valid;
	end

	always_comb begin
		hit_pos   = '0;
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i]) begin
				hit_pos   = hit_pos | CNTW'(i);
				hit_value = hit_value | ents[i].value;
			end
		end
	end

	assign lookup_hit = |match_vec;

endmodule

FILE: design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative get/put store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready (mode, key, value); each gives one result
// transfer on out_valid/out_ready (hit, read_value). A get returns the stored
// value on a hit and all ones on a miss; a put returns zero.
// Entries sit in a chain of cells, most recent at cell 0. An accepted item is
// compared against every cell in the next cycle (compare step); in the update
// step the chain shifts the touched or new entry to the head and the result
// is registered, raising out_valid. A new item is taken while idle or in the
// cycle its predecessor updates the chain, never during the compare step, so
// a new item enters as the last one leaves the update step.
// If out_ready is low while a result waits, the update step holds until that
// result transfers, and input stalls with it.
// capacity_in_use is written on cfg_valid/cfg_ready; the user is to write it
// only while the block is idle, which the block itself does not enforce.
// 0 acts as 1 and values above CAPACITY act as CAPACITY. Reset empties the
// cache at once (no clearing pass) and sets the capacity register to 16.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lkvc_pkg::CFG_W-1:0] capacity_in_use,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic signed [lkvc_pkg::KEY_W-1:0] key,
	input  logic signed [lkvc_pkg::VAL_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       hit,
	output logic signed [lkvc_pkg::VAL_W-1:0] read_value
);

	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int CW   = (CNTW > lkvc_pkg::CFG_W) ? CNTW : lkvc_pkg::CFG_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                   state_q;
	logic [lkvc_pkg::CFG_W-1:0]   cap_q;
	logic [CNTW-1:0]              occ_q;
	logic                         mode_q;
	logic [lkvc_pkg::KEY_W-1:0]   key_q;
	logic [lkvc_pkg::VAL_W-1:0]   value_q;
	logic                         out_valid_q;
	logic                         hit_q;
	logic [lkvc_pkg::VAL_W-1:0]   rdata_q;

	logic                         accept;
	logic                         upd_go;
	logic                         lookup_hit;
	logic [CNTW-1:0]              hit_pos;
	logic [lkvc_pkg::VAL_W-1:0]   hit_value;
	logic [CAPACITY-1:0]          valid_vec;
	logic [CAPACITY-1:0]          match_vec;
	logic [CW-1:0]                cap_ext;
	logic [CW-1:0]                eff_cap;
	logic                         full;
	logic [CNTW-1:0]              limit;
	lkvc_pkg::cell_ctl_t          ctl;
	lkvc_pkg::entry_t             head;

	assign upd_go    = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE) || upd_go;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign cap_ext = CW'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(CAPACITY)) begin
			eff_cap = CW'(CAPACITY);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign full = CW'(occ_q) >= eff_cap;

	always_comb begin
		if (lookup_hit) begin
			limit = hit_pos;
		end else if (full) begin
			limit = occ_q - CNTW'(1);
		end else begin
			limit = occ_q;
		end
	end

	assign ctl.cmp  = (state_q == ST_CMP);
	assign ctl.upd  = upd_go;
	assign ctl.head = lookup_hit || (mode_q == lkvc_pkg::MODE_PUT);

	assign head.valid = 1'b1;
	assign head.key   = key_q;
	assign head.value = (mode_q == lkvc_pkg::MODE_PUT) ? value_q : hit_value;

	lkvc_chain #(
		.CAPACITY (CAPACITY),
		.CNTW     (CNTW)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.limit      (limit),
		.key_cmp    (key_q),
		.head       (head),
		.lookup_hit (lookup_hit),
		.hit_pos    (hit_pos),
		.hit_value  (hit_value),
		.valid_vec  (valid_vec),
		.match_vec  (match_vec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= lkvc_pkg::CFG_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity_in_use;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (accept) begin
						state_q <= ST_CMP;
					end else if (upd_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (upd_go && (mode_q == lkvc_pkg::MODE_PUT) && !lookup_hit && !full) begin
				occ_q <= occ_q + CNTW'(1);
			end
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			key_q   <= key;
			value_q <= value;
		end
		if (upd_go) begin
			hit_q <= lookup_hit;
			if (mode_q == lkvc_pkg::MODE_PUT) begin
				rdata_q <= lkvc_pkg::PUT_VALUE;
			end else if (lookup_hit) begin
				rdata_q <= hit_value;
			end else begin
				rdata_q <= lkvc_pkg::MISS_VALUE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rdata_q;

	`LKVC_ASSERT_ALWAYS(a_occ_matches_valid, clk, arst_n,
		$countones(valid_vec) == int'(occ_q), "occupancy differs from valid cell count")
	`LKVC_ASSERT_ALWAYS(a_occ_bound, clk, arst_n,
		occ_q <= CNTW'(CAPACITY), "occupancy above capacity")
	`LKVC_ASSERT_IMP(a_unique_match, clk, arst_n,
		state_q == ST_UPD, $onehot0(match_vec), "key present in more than one cell")
	`LKVC_ASSERT_NEXT(a_get_keeps_occ, clk, arst_n,
		upd_go && (mode_q == lkvc_pkg::MODE_GET), $stable(occ_q), "get changed occupancy")
	`LKVC_ASSERT_NEXT(a_accept_to_cmp, clk, arst_n,
		accept, state_q == ST_CMP, "accepted item skipped the compare step")

endmodule
